>>> hw/rtl/lfo_sine_triangle_generator_defines.svh
// assertion macros used by the lfo phase rtl
`ifndef LFO_SINE_TRIANGLE_GENERATOR_DEFINES_SVH
`define LFO_SINE_TRIANGLE_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LFO_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfo: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define LFO_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfo: next-cycle check failed");

`endif

>>> hw/rtl/lfo_pkg.sv
package lfo_pkg;

  // parameter defaults
  localparam int unsigned PHASE_BITS_DEF      = 32;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;

  // field widths
  localparam int unsigned CV_W       = 16;
  localparam int unsigned KNOB_W     = 16;
  localparam int unsigned HZ_W       = 24;
  localparam int unsigned FQ_W       = 19;
  localparam int unsigned PROD_W     = FQ_W + HZ_W;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned AMP_W      = 15;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 24;

  // fraction bits of frequency (q16) times step (q0.32)
  localparam int unsigned FIX_FRAC_BITS = 48;

  // levels, 4096 lsb per volt
  localparam int FULL_SCALE = 20480;
  localparam logic signed [CV_W-1:0] CV_MAX          = 16'sd20480;
  localparam logic signed [CV_W-1:0] RESET_THRESHOLD = 16'sd12288;

  // register reset values
  localparam logic [KNOB_W-1:0] FREQ_KNOB_RST = 16'd6554;
  localparam logic [HZ_W-1:0]   HZ_STEP_RST   = 24'd89478;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREQ_KNOB = 1'b0,
    CFG_HZ_STEP   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [KNOB_W-1:0] freq_knob;
    logic [HZ_W-1:0]   hz_step;
  } cfg_t;

  typedef struct packed {
    logic sine;
    logic unipolar;
  } mode_t;

endpackage

>>> hw/rtl/lfo_if.sv
// sample tick request channel
interface lfo_in_if;
  import lfo_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [CV_W-1:0] freq_cv;
  logic signed [CV_W-1:0] reset_cv;
  logic [KNOB_W-1:0]      phase_knob;
  logic                   shape_button;
  logic                   polarity_button;

  modport source (output valid, freq_cv, reset_cv, phase_knob, shape_button,
                  polarity_button, input ready);
  modport sink (input valid, freq_cv, reset_cv, phase_knob, shape_button,
                polarity_button, output ready);
endinterface

// output sample request channel
interface lfo_out_if;
  import lfo_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [LEVEL_W-1:0] out_level;
  logic                      sine_selected;
  logic                      unipolar_selected;

  modport source (output valid, out_level, sine_selected, unipolar_selected,
                  input ready);
  modport sink (input valid, out_level, sine_selected, unipolar_selected,
                output ready);
endinterface

>>> hw/rtl/lfo_phase.sv
`include "lfo_sine_triangle_generator_defines.svh"

module lfo_phase #(
  parameter int unsigned PHASE_BITS = lfo_pkg::PHASE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lfo_pkg::cfg_t                  cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [lfo_pkg::CV_W-1:0] freq_cv_i,
  input  logic signed [lfo_pkg::CV_W-1:0] reset_cv_i,
  input  logic [lfo_pkg::KNOB_W-1:0]     phase_knob_i,
  input  logic                           shape_button_i,
  input  logic                           polarity_button_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [PHASE_BITS-1:0]          phase_o,
  output lfo_pkg::mode_t                 mode_o
);
  import lfo_pkg::*;

  localparam int unsigned INC_LSB = FIX_FRAC_BITS - PHASE_BITS;

  // stage valids and ready chain
  logic v1_q, v2_q, v3_q;
  logic r1, r2, r3, adv1, adv2;

  // stage 1 payload
  logic signed [CV_W-1:0] fcv1_q, rcv1_q;
  logic [KNOB_W-1:0]      knob1_q;
  logic                   shb1_q, plb1_q;

  // per-item state
  logic [KNOB_W-1:0]     last_knob_q;
  logic                  latched_q, latch_d;
  logic                  shb_prev_q, plb_prev_q;
  mode_t                 mode_q, mode_d;
  logic [PHASE_BITS-1:0] phase_q;

  // stage 2 and stage 3 payload
  logic [PHASE_BITS-1:0] inc2_q, delta2_q;
  logic                  zero2_q;
  mode_t                 mode2_q;
  mode_t                 mode3_q;

  // stage 1 combinational results
  logic [AMP_W-1:0]      cv_clamp;
  logic [FQ_W-1:0]       fq;
  logic [PROD_W-1:0]     prod;
  logic [KNOB_W-1:0]     knob_diff;
  logic                  gt_thr, lt_thr, zero_d;

  assign r3   = !v3_q || ready_i;
  assign adv2 = v2_q && r3;
  assign r2   = !v2_q || r3;
  assign adv1 = v1_q && r2;
  assign r1   = !v1_q || r2;
  assign in_ready_o = r1;

  // frequency cv clamp to 0..5 v
  always_comb begin
    if (fcv1_q < 0) begin
      cv_clamp = '0;
    end else if (fcv1_q > CV_MAX) begin
      cv_clamp = AMP_W'(CV_MAX);
    end else begin
      cv_clamp = fcv1_q[AMP_W-1:0];
    end
  end

  // frequency in q16 hz and phase increment product
  assign fq   = FQ_W'(cfg_i.freq_knob) + (FQ_W'(cfg_i.freq_knob) << 2)
              + (FQ_W'(cv_clamp) << 3);
  assign prod = PROD_W'(fq) * PROD_W'(cfg_i.hz_step);

  // knob delta and reset latch
  assign knob_diff = knob1_q - last_knob_q;
  assign gt_thr    = rcv1_q > RESET_THRESHOLD;
  assign lt_thr    = rcv1_q < RESET_THRESHOLD;
  assign zero_d    = gt_thr && !latched_q;

  always_comb begin
    if (zero_d) begin
      latch_d = 1'b1;
    end else if (lt_thr && latched_q) begin
      latch_d = 1'b0;
    end else begin
      latch_d = latched_q;
    end
  end

  // button rising edges toggle modes
  always_comb begin
    mode_d          = mode_q;
    mode_d.sine     = mode_q.sine ^ (shb1_q & ~shb_prev_q);
    mode_d.unipolar = mode_q.unipolar ^ (plb1_q & ~plb_prev_q);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  // stage 1 input register
  always_ff @(posedge clk_i) begin
    if (r1) begin
      fcv1_q  <= freq_cv_i;
      rcv1_q  <= reset_cv_i;
      knob1_q <= phase_knob_i;
      shb1_q  <= shape_button_i;
      plb1_q  <= polarity_button_i;
    end
  end

  // item state updated in item order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_knob_q <= '0;
      latched_q   <= 1'b0;
      shb_prev_q  <= 1'b0;
      plb_prev_q  <= 1'b0;
      mode_q      <= '{sine: 1'b1, unipolar: 1'b1};
    end else if (adv1) begin
      last_knob_q <= knob1_q;
      latched_q   <= latch_d;
      shb_prev_q  <= shb1_q;
      plb_prev_q  <= plb1_q;
      mode_q      <= mode_d;
    end
  end

  // stage 2 register
  always_ff @(posedge clk_i) begin
    if (r2) begin
      inc2_q   <= PHASE_BITS'(prod[PROD_W-1:INC_LSB]);
      delta2_q <= PHASE_BITS'(knob_diff) << (PHASE_BITS - KNOB_W);
      zero2_q  <= zero_d;
      mode2_q  <= mode_d;
    end
  end

  // phase accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (adv2) begin
      phase_q <= zero2_q ? '0 : phase_q + inc2_q + delta2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r3) begin
      mode3_q <= mode2_q;
    end
  end

  assign valid_o = v3_q;
  assign phase_o = phase_q;
  assign mode_o  = mode3_q;

  `LFO_ASSERT_NEXT(a_reset_zeroes_phase, clk_i, rst_ni, adv2 && zero2_q, phase_q == '0)
  `LFO_ASSERT_NEXT(a_phase_holds_idle, clk_i, rst_ni, !adv2, $stable(phase_q))
  `LFO_ASSERT_NEXT(a_shape_toggle, clk_i, rst_ni, adv1 && shb1_q && !shb_prev_q, mode_q.sine != $past(mode_q.sine))
  `LFO_ASSERT_NOW(a_full_stall_blocks, clk_i, rst_ni, v1_q && v2_q && v3_q && !ready_i, !in_ready_o)

endmodule

>>> hw/rtl/lfo_wave.sv
module lfo_wave #(
  parameter int unsigned PHASE_BITS      = lfo_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_BITS = lfo_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [PHASE_BITS-1:0]             phase_i,
  input  lfo_pkg::mode_t                    mode_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [lfo_pkg::LEVEL_W-1:0] out_level_o,
  output lfo_pkg::mode_t                    mode_o
);
  import lfo_pkg::*;

  localparam int unsigned N      = 1 << SINE_TABLE_BITS;
  localparam int unsigned ADDR_W = SINE_TABLE_BITS + 1;
  localparam int unsigned TRI_W  = 18;
  localparam int unsigned T_W    = 17;

  // q30 taylor coefficients of sin(pi/2 x)
  localparam longint unsigned Q30_HALF = 64'd536870912;
  localparam longint unsigned C1 = 64'd1686629713;
  localparam longint unsigned C3 = 64'd693598668;
  localparam longint unsigned C5 = 64'd85569306;
  localparam longint unsigned C7 = 64'd5026995;
  localparam longint unsigned C9 = 64'd172272;

  typedef logic [AMP_W-1:0] sine_rom_t [N+1];

  // quarter-wave table built at elaboration
  function automatic sine_rom_t gen_sine_rom();
    sine_rom_t       rom;
    longint unsigned x, x2, p, s, r;
    int unsigned     i;
    for (i = 0; i <= N; i++) begin
      x  = longint'(i) << (30 - SINE_TABLE_BITS);
      x2 = (x * x) >> 30;
      p  = C9;
      p  = C7 - ((x2 * p) >> 30);
      p  = C5 - ((x2 * p) >> 30);
      p  = C3 - ((x2 * p) >> 30);
      p  = C1 - ((x2 * p) >> 30);
      s  = (x * p) >> 30;
      r  = (s * longint'(FULL_SCALE) + Q30_HALF) >> 30;
      if (r > longint'(FULL_SCALE)) r = longint'(FULL_SCALE);
      rom[i] = AMP_W'(r);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = gen_sine_rom();

  localparam logic signed [TRI_W-1:0] TRI_FS  = TRI_W'(FULL_SCALE);
  localparam logic signed [TRI_W-1:0] TRI_FS3 = TRI_W'(3 * FULL_SCALE);
  localparam logic signed [LEVEL_W:0] LVL_FS  = (LEVEL_W + 1)'(FULL_SCALE);

  logic v4_q, v5_q, r4, r5;

  // stage 4 payload
  logic [AMP_W-1:0]          amp4_q;
  logic                      neg4_q;
  logic signed [LEVEL_W-1:0] tri4_q;
  mode_t                     mode4_q;

  // stage 5 payload
  logic signed [LEVEL_W-1:0] level5_q;
  mode_t                     mode5_q;

  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] k;
  logic [ADDR_W-1:0]          addr;
  logic [PHASE_BITS+2:0]      p5;
  logic [T_W-1:0]             t;
  logic signed [TRI_W-1:0]    tri_lvl;
  logic signed [LEVEL_W:0]    amp_s, bip, uni_sum;
  logic signed [LEVEL_W-1:0]  level_d;

  assign r5      = !v5_q || out_ready_i;
  assign r4      = !v4_q || r5;
  assign ready_o = r4;

  // quadrant and table address, mirrored in odd quadrants
  assign quad = phase_i[PHASE_BITS-1 -: 2];
  assign k    = phase_i[PHASE_BITS-3 -: SINE_TABLE_BITS];
  assign addr = quad[0] ? ADDR_W'(N) - {1'b0, k} : {1'b0, k};

  // triangle from phase times 5
  assign p5 = {3'b000, phase_i} + {1'b0, phase_i, 2'b00};
  assign t  = p5[PHASE_BITS+2:PHASE_BITS-14];

  always_comb begin
    if (phase_i <= (PHASE_BITS'(1) << (PHASE_BITS - 1))) begin
      tri_lvl = $signed({1'b0, t}) - TRI_FS;
    end else begin
      tri_lvl = TRI_FS3 - $signed({1'b0, t});
    end
  end

  // shape select, sign and polarity offset
  assign amp_s   = $signed({2'b00, amp4_q});
  assign bip     = mode4_q.sine ? (neg4_q ? -amp_s : amp_s) : (LEVEL_W + 1)'(tri4_q);
  assign uni_sum = bip + LVL_FS;
  assign level_d = mode4_q.unipolar ? uni_sum[LEVEL_W:1] : bip[LEVEL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (r4) v4_q <= valid_i;
      if (r5) v5_q <= v4_q;
    end
  end

  // table read and triangle register
  always_ff @(posedge clk_i) begin
    if (r4) begin
      amp4_q  <= SINE_ROM[addr];
      neg4_q  <= quad[1];
      tri4_q  <= tri_lvl[LEVEL_W-1:0];
      mode4_q <= mode_i;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (r5) begin
      level5_q <= level_d;
      mode5_q  <= mode4_q;
    end
  end

  assign out_valid_o = v5_q;
  assign out_level_o = level5_q;
  assign mode_o      = mode5_q;

endmodule

>>> hw/rtl/lfo_sine_triangle_generator.sv
// lfo with sine and triangle shapes, one output sample per sample tick.
// in_i carries one request per tick: frequency cv, reset cv, phase knob
// and the two button levels. out_o returns one request per tick: the
// output level (4096 lsb per volt) and the current shape and polarity.
// cfg_we_i writes freq_knob (index 0) or hz_step (index 1) from cfg_data_i;
// write only while no tick is in flight.
// an accepted tick passes the input register, increment multiply,
// phase accumulate, sine table read and output register in turn.
// throughput: one tick per cycle while the receiver keeps out_o.ready
// high.
// reset: phase and knob memory clear, sine and unipolar selected, the
// configuration returns to its reset values and the pipeline empties.
// a stalled receiver holds the output register; stages behind it keep
// filling bubbles, and in_i.ready drops only once every stage is full.
module lfo_sine_triangle_generator #(
  parameter int unsigned PHASE_BITS      = lfo_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_BITS = lfo_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lfo_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lfo_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  lfo_in_if.sink                          in_i,
  lfo_out_if.source                       out_o
);
  import lfo_pkg::*;

  cfg_t                  cfg_q;
  logic                  mid_valid, mid_ready;
  logic [PHASE_BITS-1:0] mid_phase;
  mode_t                 mid_mode, out_mode;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.freq_knob <= FREQ_KNOB_RST;
      cfg_q.hz_step   <= HZ_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FREQ_KNOB: cfg_q.freq_knob <= cfg_data_i[KNOB_W-1:0];
        CFG_HZ_STEP:   cfg_q.hz_step   <= cfg_data_i[HZ_W-1:0];
        default: ;
      endcase
    end
  end

  // phase accumulator front end
  lfo_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .in_valid_i        (in_i.valid),
    .in_ready_o        (in_i.ready),
    .freq_cv_i         (in_i.freq_cv),
    .reset_cv_i        (in_i.reset_cv),
    .phase_knob_i      (in_i.phase_knob),
    .shape_button_i    (in_i.shape_button),
    .polarity_button_i (in_i.polarity_button),
    .valid_o           (mid_valid),
    .ready_i           (mid_ready),
    .phase_o           (mid_phase),
    .mode_o            (mid_mode)
  );

  // waveform back end
  lfo_wave #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_wave (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (mid_valid),
    .ready_o     (mid_ready),
    .phase_i     (mid_phase),
    .mode_i      (mid_mode),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_level_o (out_o.out_level),
    .mode_o      (out_mode)
  );

  assign out_o.sine_selected     = out_mode.sine;
  assign out_o.unipolar_selected = out_mode.unipolar;

endmodule
